@@ rtl/thermistor_beta_to_celsius_assert.svh @@
// Assertion macros for the thermistor Beta converter.
// Used by the modules that check their own control logic; needs clk and rst_n in scope.
`ifndef THERMISTOR_BETA_TO_CELSIUS_ASSERT_SVH
`define THERMISTOR_BETA_TO_CELSIUS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TBC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBC_ASSERT(lbl, prop, msg)
`define TBC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ rtl/tbc_pkg.sv @@
// Shared constants, types and helper functions of the thermistor Beta converter.
// No dependencies.
package tbc_pkg;

  localparam int ADC_BITS   = 12;
  localparam int K_W        = $clog2(ADC_BITS);
  localparam int Q_FRAC     = 30;
  localparam int MANT_W     = Q_FRAC + 1;
  localparam int LOG_W      = K_W + Q_FRAC;
  localparam int LOG_STEPS  = Q_FRAC;
  localparam int LCNT_W     = $clog2(LOG_STEPS);
  localparam int MAG_W      = LOG_W;
  localparam int ML_W       = (MAG_W + 1) / 2;
  localparam int MH_W       = MAG_W - ML_W;
  localparam int LN2_W      = 30;
  localparam int PP_W       = ML_W + LN2_W;
  localparam int PROD_W     = MAG_W + LN2_W;
  localparam int TERM_SHIFT = 12;
  localparam int DIV_N      = 56;
  localparam int DIV_D      = 52;
  localparam int DCNT_W     = $clog2(DIV_N);
  localparam int INV0_W     = 44;
  localparam int INV_W      = DIV_D + 2;
  localparam int TEMP_W     = 18;
  localparam int REF_W      = 15;
  localparam int BETA_W     = 16;
  localparam int T0_W       = 16;

  localparam logic [LN2_W-1:0]  LN2_Q30   = 30'd744261118;
  localparam logic [DIV_N-1:0]  ONE_Q48   = 56'd100 << 48;
  localparam logic [ADC_BITS:0] FULL_SCALE = (ADC_BITS+1)'(1) << ADC_BITS;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd100000;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -18'sd27315;
  localparam logic [TEMP_W-1:0] KELVIN_OFF = 18'd27315;
  localparam logic [DIV_N-1:0]  TK_MAX     = 56'd127315;

  // Register indexes
  localparam logic [1:0] REG_BETA = 2'd0;
  localparam logic [1:0] REG_REF  = 2'd1;

  typedef struct packed {
    logic              zero;
    logic [K_W-1:0]    kc;
    logic [K_W-1:0]    kd;
    logic [MANT_W-1:0] mc;
    logic [MANT_W-1:0] md;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [K_W-1:0] lead_pos(input logic [ADC_BITS-1:0] x);
    logic [K_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < ADC_BITS; i++) begin
      if (x[i]) pos = K_W'(i);
    end
    return pos;
  endfunction

  // Normalize x to Q30 in [1,2)
  function automatic logic [MANT_W-1:0] norm_mant(input logic [ADC_BITS-1:0] x,
                                                  input logic [K_W-1:0] k);
    logic [MANT_W-1:0] w;
    w = MANT_W'(x);
    return w << (Q_FRAC - int'(k));
  endfunction

endpackage

@@ rtl/tbc_log2.sv @@
// Bitwise log2 unit: one squaring step per cycle, Q30 fraction.
// Depends on tbc_pkg.
module tbc_log2 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [tbc_pkg::K_W-1:0]        k,
  input  logic [tbc_pkg::MANT_W-1:0]     mant,
  output logic [tbc_pkg::LOG_W-1:0]      result
);

  logic                            run_r;
  logic [tbc_pkg::LCNT_W-1:0]      cnt_r;
  logic [tbc_pkg::MANT_W-1:0]      m_r;
  logic [tbc_pkg::Q_FRAC-1:0]      frac_r;
  logic [tbc_pkg::K_W-1:0]         k_r;
  logic [2*tbc_pkg::MANT_W-1:0]    sq;
  logic [tbc_pkg::MANT_W:0]        m2;
  logic                            bitv;

  always_comb begin
    sq   = m_r * m_r;
    m2   = sq[2*tbc_pkg::MANT_W-1:tbc_pkg::Q_FRAC];
    bitv = m2[tbc_pkg::MANT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (load) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == tbc_pkg::LCNT_W'(tbc_pkg::LOG_STEPS - 1)) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_r    <= mant;
      k_r    <= k;
      frac_r <= '0;
    end else if (run_r) begin
      m_r    <= bitv ? m2[tbc_pkg::MANT_W:1] : m2[tbc_pkg::MANT_W-1:0];
      frac_r <= {frac_r[tbc_pkg::Q_FRAC-2:0], bitv};
    end
  end

  assign result = {k_r, frac_r};

endmodule

@@ rtl/tbc_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on tbc_pkg.
module tbc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [tbc_pkg::DIV_N-1:0]     dividend,
  input  logic [tbc_pkg::DIV_D-1:0]     divisor,
  output tbc_pkg::div_stat_t            stat,
  output logic [tbc_pkg::DIV_N-1:0]     quotient
);

  logic                          run_r;
  logic                          done_r;
  logic [tbc_pkg::DCNT_W-1:0]    cnt_r;
  logic [tbc_pkg::DIV_D-1:0]     rem_r;
  logic [tbc_pkg::DIV_D-1:0]     div_r;
  logic [tbc_pkg::DIV_N-1:0]     dq_r;
  logic [tbc_pkg::DIV_D:0]       trial;
  logic [tbc_pkg::DIV_D:0]       diff;
  logic                          ge;

  always_comb begin
    trial = {rem_r, dq_r[tbc_pkg::DIV_N-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tbc_pkg::DCNT_W'(tbc_pkg::DIV_N - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      div_r <= divisor;
      dq_r  <= dividend;
    end else if (run_r) begin
      rem_r <= ge ? diff[tbc_pkg::DIV_D-1:0] : trial[tbc_pkg::DIV_D-1:0];
      dq_r  <= {dq_r[tbc_pkg::DIV_N-2:0], ge};
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

@@ rtl/tbc_front.sv @@
// Front end: takes words, flags a zero code, normalizes code and divider complement,
// and holds them in a two-entry queue for the back end. Depends on tbc_pkg.
module tbc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tbc_pkg::ADC_BITS-1:0]   in_adc_code,
  input  logic                           q_pop,
  output logic                           q_valid,
  output tbc_pkg::item_t                 q_item
);

  tbc_pkg::item_t                  ent_r [2];
  logic                            wp_r;
  logic                            rp_r;
  logic [1:0]                      cnt_r;
  logic [1:0]                      cnt_nxt;
  logic                            push;
  logic [tbc_pkg::ADC_BITS:0]      den_w;
  logic [tbc_pkg::ADC_BITS-1:0]    den;
  tbc_pkg::item_t                  item;

  always_comb begin
    den_w     = tbc_pkg::FULL_SCALE - {1'b0, in_adc_code};
    den       = den_w[tbc_pkg::ADC_BITS-1:0];
    item.zero = (in_adc_code == '0);
    item.kc   = tbc_pkg::lead_pos(in_adc_code);
    item.kd   = tbc_pkg::lead_pos(den);
    item.mc   = tbc_pkg::norm_mant(in_adc_code, item.kc);
    item.md   = tbc_pkg::norm_mant(den, item.kd);
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= item;
  end

endmodule

@@ rtl/tbc_back.sv @@
// Back end: sequences log2, ln2 scaling, Beta and Kelvin divisions, clamps and emits.
// Depends on tbc_pkg, tbc_log2, tbc_div and the assertion header.
`include "thermistor_beta_to_celsius_assert.svh"
module tbc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  tbc_pkg::item_t                        q_item,
  output logic                                  q_pop,
  input  logic [tbc_pkg::BETA_W-1:0]            beta,
  input  logic signed [tbc_pkg::REF_W-1:0]      ref_temp,
  output logic                                  out_valid,
  output logic signed [tbc_pkg::TEMP_W-1:0]     out_temp_centi,
  output logic                                  out_out_of_range
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOG  = 3'd1;
  localparam logic [2:0] ST_MUL0 = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_TLD  = 3'd4;
  localparam logic [2:0] ST_DIVT = 3'd5;
  localparam logic [2:0] ST_INV  = 3'd6;
  localparam logic [2:0] ST_DIVK = 3'd7;

  logic [2:0]                             state_r, state_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  logic signed [tbc_pkg::TEMP_W-1:0]      temp_r, temp_nxt;
  logic                                   flag_r, flag_nxt;
  logic [tbc_pkg::INV0_W-1:0]             inv0_r;
  logic                                   neg_r;
  logic [tbc_pkg::MAG_W-1:0]              mag_r;
  logic [tbc_pkg::PROD_W-1:0]             prod_r;
  logic signed [tbc_pkg::INV_W-1:0]       inv_r;

  logic [tbc_pkg::LOG_W-1:0]              lc, ld;
  logic                                   log_load;
  logic                                   div_load;
  logic [tbc_pkg::DIV_N-1:0]              div_dvd;
  logic [tbc_pkg::DIV_D-1:0]              div_dvs;
  tbc_pkg::div_stat_t                     div_stat;
  logic [tbc_pkg::DIV_N-1:0]              quo;

  logic [tbc_pkg::BETA_W-1:0]             beta_eff;
  logic signed [tbc_pkg::T0_W:0]          t0_s;
  logic [tbc_pkg::ML_W-1:0]               mul_a;
  logic [tbc_pkg::PP_W-1:0]               pp;
  logic [tbc_pkg::DIV_D-1:0]              u;
  logic signed [tbc_pkg::INV_W-1:0]       inv_nxt;
  logic [tbc_pkg::TEMP_W-1:0]             tk_lo;

  tbc_log2 u_log_code (
    .clk(clk), .rst_n(rst_n), .load(log_load),
    .k(q_item.kc), .mant(q_item.mc), .result(lc)
  );

  tbc_log2 u_log_den (
    .clk(clk), .rst_n(rst_n), .load(log_load),
    .k(q_item.kd), .mant(q_item.md), .result(ld)
  );

  tbc_div u_div (
    .clk(clk), .rst_n(rst_n), .load(div_load),
    .dividend(div_dvd), .divisor(div_dvs), .stat(div_stat), .quotient(quo)
  );

  always_comb begin
    beta_eff = (beta == '0) ? tbc_pkg::BETA_W'(1) : beta;
    t0_s     = (tbc_pkg::T0_W+1)'(ref_temp) + (tbc_pkg::T0_W+1)'(27315);
    mul_a    = (state_r == ST_MUL0) ? tbc_pkg::ML_W'(mag_r[tbc_pkg::MAG_W-1:tbc_pkg::ML_W])
                                    : mag_r[tbc_pkg::ML_W-1:0];
    pp       = tbc_pkg::PP_W'(mul_a) * tbc_pkg::PP_W'(tbc_pkg::LN2_Q30);
    u        = inv_r[tbc_pkg::DIV_D-1:0];
    inv_nxt  = neg_r ? tbc_pkg::INV_W'(inv0_r) - tbc_pkg::INV_W'(quo[tbc_pkg::DIV_D-1:0])
                     : tbc_pkg::INV_W'(inv0_r) + tbc_pkg::INV_W'(quo[tbc_pkg::DIV_D-1:0]);
    tk_lo    = quo[tbc_pkg::TEMP_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    temp_nxt      = temp_r;
    flag_nxt      = flag_r;
    q_pop         = 1'b0;
    log_load      = 1'b0;
    div_load      = 1'b0;
    div_dvd       = tbc_pkg::ONE_Q48;
    div_dvs       = tbc_pkg::DIV_D'(t0_s[tbc_pkg::T0_W-1:0]);
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.zero) begin
            out_valid_nxt = 1'b1;
            temp_nxt      = tbc_pkg::TEMP_MAX;
            flag_nxt      = 1'b1;
          end else begin
            log_load  = 1'b1;
            div_load  = 1'b1;
            state_nxt = ST_LOG;
          end
        end
      end
      ST_LOG: begin
        // log2 units finish well inside the 1/T0 division
        if (div_stat.done) state_nxt = ST_MUL0;
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_TLD;
      ST_TLD: begin
        div_load  = 1'b1;
        div_dvd   = tbc_pkg::DIV_N'(prod_r >> tbc_pkg::TERM_SHIFT);
        div_dvs   = tbc_pkg::DIV_D'(beta_eff);
        state_nxt = ST_DIVT;
      end
      ST_DIVT: begin
        if (div_stat.done) state_nxt = ST_INV;
      end
      ST_INV: begin
        if (inv_r <= 0) begin
          out_valid_nxt = 1'b1;
          temp_nxt      = tbc_pkg::TEMP_MAX;
          flag_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          div_load  = 1'b1;
          div_dvd   = tbc_pkg::ONE_Q48 + tbc_pkg::DIV_N'(u >> 1);
          div_dvs   = u;
          state_nxt = ST_DIVK;
        end
      end
      ST_DIVK: begin
        if (div_stat.done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (quo > tbc_pkg::TK_MAX) begin
            temp_nxt = tbc_pkg::TEMP_MAX;
            flag_nxt = 1'b1;
          end else begin
            temp_nxt = $signed(tk_lo - tbc_pkg::KELVIN_OFF);
            flag_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_r <= temp_nxt;
    flag_r <= flag_nxt;
    if (state_r == ST_LOG && div_stat.done) begin
      inv0_r <= quo[tbc_pkg::INV0_W-1:0];
      neg_r  <= lc < ld;
      mag_r  <= (lc < ld) ? ld - lc : lc - ld;
    end
    if (state_r == ST_MUL0) prod_r <= tbc_pkg::PROD_W'(pp);
    if (state_r == ST_MUL1)
      prod_r <= (prod_r << tbc_pkg::ML_W) + tbc_pkg::PROD_W'(pp);
    if (state_r == ST_DIVT && div_stat.done) inv_r <= inv_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_temp_centi   = temp_r;
  assign out_out_of_range = flag_r;

  `TBC_ASSERT(a_pop_only_idle, q_pop |-> state_r == ST_IDLE, "pop outside idle")
  `TBC_ASSERT(a_div_free, div_load |-> !div_stat.busy, "divider loaded while busy")
  `TBC_ASSERT(a_out_bounds, out_valid |-> (out_temp_centi <= tbc_pkg::TEMP_MAX && out_temp_centi >= tbc_pkg::TEMP_MIN), "result out of bounds")
  `TBC_ASSERT(a_clean_from_div, (out_valid && !out_out_of_range) |-> $past(state_r) == ST_DIVK, "unflagged result without final division")
  `TBC_ASSERT_NR(a_quiet_reset, !rst_n |=> !out_valid, "strobe right after reset")

endmodule

@@ rtl/thermistor_beta_to_celsius.sv @@
// NTC thermistor converter, Beta equation: ADC code in, temperature in 0.01 C out.
// Depends on tbc_pkg, tbc_front, tbc_back.
//
// A word is taken on any rising edge with start high and busy low; the front end
// normalizes it and parks it in a two-entry queue, so start may be pulsed again
// while the back end is still working. busy rises only when that queue is full.
// Each result shows on out_temp_centi / out_out_of_range for exactly one cycle
// with out_valid high; the receiver cannot stall, so capture it then. A normal
// code runs in the back end as a division for 1/T0 (the two 30-step log2 units
// run beside it), a split multiply by ln2 (upper half, then lower half), then a
// division by Beta and a division for the kelvin value, all on one shared
// radix-2 divider, which sets the rate. A zero code is answered in the cycle
// after the back end pops it, with no division. Code zero, a non-positive inverse
// temperature or a clamped result raise out_of_range. Write beta_kelvin (index 0)
// and reference_temp_centi (index 1) on the cfg_ port only while no conversion is
// pending; cfg_ready is always high and other indexes are dropped.
module thermistor_beta_to_celsius (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [tbc_pkg::ADC_BITS-1:0]          in_adc_code,
  output logic                                  out_valid,
  output logic signed [tbc_pkg::TEMP_W-1:0]     out_temp_centi,
  output logic                                  out_out_of_range,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [15:0]                           cfg_data
);

  logic [tbc_pkg::BETA_W-1:0]         beta_r;
  logic signed [tbc_pkg::REF_W-1:0]   ref_r;
  logic                               q_valid;
  logic                               q_pop;
  tbc_pkg::item_t                     q_item;

  assign cfg_ready = 1'b1;

  // Config registers: hold until rewritten; drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= 16'd3950;
      ref_r  <= 15'sd2500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbc_pkg::REG_BETA: beta_r <= cfg_data;
        tbc_pkg::REG_REF:  ref_r  <= $signed(cfg_data[tbc_pkg::REF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Front end: accept, classify, normalize, queue.
  tbc_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_adc_code(in_adc_code), .q_pop(q_pop), .q_valid(q_valid), .q_item(q_item)
  );

  // Back end: run the Beta equation and emit one strobed word per item.
  tbc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .beta(beta_r), .ref_temp(ref_r), .out_valid(out_valid),
    .out_temp_centi(out_temp_centi), .out_out_of_range(out_out_of_range)
  );

endmodule

@@ tb/tb_thermistor_beta_to_celsius.sv @@
// Self-checking testbench for thermistor_beta_to_celsius: ADC codes in, temperatures out.
// Depends on tbc_pkg for the port widths and register indexes; predicts each word
// in fixed point unless a directed row gives it, and compares it with the results in order.
module tb_thermistor_beta_to_celsius;

  localparam int GAP_MAX    = 17;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_WORDS = 175;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic [tbc_pkg::ADC_BITS-1:0]       in_adc_code;
  logic                               out_valid;
  logic signed [tbc_pkg::TEMP_W-1:0]  out_temp_centi;
  logic                               out_out_of_range;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [1:0]                         cfg_index;
  logic [15:0]                        cfg_data;

  typedef struct packed {
    logic signed [tbc_pkg::TEMP_W-1:0] temp;
    logic                              flag;
  } reading_t;

  // One directed row: code, and the expected reading where it is known up front
  typedef struct {
    logic [tbc_pkg::ADC_BITS-1:0]      code;
    bit                                typed;
    logic signed [tbc_pkg::TEMP_W-1:0] temp;
    logic                              flag;
  } probe_t;

  reading_t   pending_readings[$];
  logic [15:0] beta_reg;
  logic signed [tbc_pkg::REF_W-1:0] ref_reg;
  int mismatches, readings_seen, words_sent, idle_cycles;

  thermistor_beta_to_celsius uut (
    .clk, .rst_n, .start, .busy, .in_adc_code, .out_valid, .out_temp_centi,
    .out_out_of_range, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // log2 of x in Q30 by repeated squaring, truncating at every step
  function automatic longint unsigned bin_log_q30(input longint unsigned x);
    longint unsigned k, m, frac;
    k = 0;
    frac = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = x << (30 - k);
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac |= 64'd1 << i;
      end
    end
    return (k << 30) | frac;
  endfunction

  // Beta equation in Q48 inverse kelvin, with the same saturation rules as the block
  function automatic reading_t celsius_from_code(input logic [tbc_pkg::ADC_BITS-1:0] code);
    longint unsigned full, beta, one_q48, lc, ld, mag, term, t0, u;
    longint inv, tk, temp;
    bit neg, flag;
    reading_t r;
    full = 64'd1 << tbc_pkg::ADC_BITS;
    beta = (beta_reg == 0) ? 64'd1 : 64'(beta_reg);
    one_q48 = 64'd100 << 48;
    flag = 0;
    if (code == 0) begin
      temp = 100000;
      flag = 1;
    end else begin
      lc = bin_log_q30(64'(code));
      ld = bin_log_q30(full - 64'(code));
      neg = lc < ld;
      mag = neg ? ld - lc : lc - ld;
      term = ((mag * 64'd744261118) / beta) >> 12;
      t0 = 64'(longint'(ref_reg) + 27315);
      inv = longint'(one_q48 / t0);
      inv = neg ? inv - longint'(term) : inv + longint'(term);
      if (inv <= 0) begin
        temp = 100000;
        flag = 1;
      end else begin
        u = 64'(inv);
        tk = longint'((one_q48 + u / 2) / u);
        temp = tk - 27315;
        if (temp > 100000) begin
          temp = 100000;
          flag = 1;
        end else if (temp < -27315) begin
          temp = -27315;
          flag = 1;
        end
      end
    end
    r.temp = tbc_pkg::TEMP_W'(temp);
    r.flag = flag;
    return r;
  endfunction

  // Send one word after an idle gap; keep start high across back-to-back words
  task automatic send_code(input logic [tbc_pkg::ADC_BITS-1:0] code, input int gap,
                           input bit typed, input reading_t typed_val);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_adc_code <= code;
    do @(posedge clk); while (busy);
    pending_readings.push_back(typed ? typed_val : celsius_from_code(code));
    words_sent++;
  endtask

  // Drain everything outstanding, then let the back end settle before a write
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Hold valid high across consecutive writes; the caller drops it after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    // Mirror the register file; unknown indexes are dropped by the block
    if (idx == tbc_pkg::REG_BETA) beta_reg = data;
    else if (idx == tbc_pkg::REG_REF) ref_reg = data[tbc_pkg::REF_W-1:0];
  endtask

  // Check each result against the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result temp=%0d flag=%0b",
                                       out_temp_centi, out_out_of_range);
      end else begin
        reading_t want;
        want = pending_readings.pop_front();
        if (want.temp !== out_temp_centi || want.flag !== out_out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected temp=%0d flag=%0b, got temp=%0d flag=%0b",
                     want.temp, want.flag, out_temp_centi, out_out_of_range);
        end
      end
    end
  end

  // Watchdog: count cycles in which no handshake of any kind completes
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [tbc_pkg::ADC_BITS-1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 19);
    unique case (sel)
      0: return '0;
      1: return tbc_pkg::ADC_BITS'(1);
      2: return {tbc_pkg::ADC_BITS{1'b1}};
      3: return 12'd2048;
      default: return tbc_pkg::ADC_BITS'($urandom);
    endcase
  endfunction

  initial begin
    probe_t probes[$];
    reading_t typed_val;
    logic [15:0] beta_set[8];
    logic [15:0] ref_set[8];
    int ngap;

    rst_n = 1'b0;
    start = 1'b0;
    in_adc_code = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    beta_reg = 16'd3950;
    ref_reg = 15'sd2500;
    mismatches = 0;
    readings_seen = 0;
    words_sent = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings: zero code saturates hot, the rest is predicted
    probes.push_back('{12'd0,    1, 18'sd100000, 1'b1});
    probes.push_back('{12'd1,    0, '0, 1'b0});
    probes.push_back('{12'd2,    0, '0, 1'b0});
    probes.push_back('{12'd2048, 0, '0, 1'b0});
    probes.push_back('{12'd2047, 0, '0, 1'b0});
    probes.push_back('{12'd2049, 0, '0, 1'b0});
    probes.push_back('{12'd4094, 0, '0, 1'b0});
    probes.push_back('{12'd4095, 0, '0, 1'b0});
    probes.push_back('{12'd0,    1, 18'sd100000, 1'b1});
    probes.push_back('{12'hAAA,  0, '0, 1'b0});
    probes.push_back('{12'h555,  0, '0, 1'b0});
    probes.push_back('{12'd100,  0, '0, 1'b0});
    probes.push_back('{12'd3500, 0, '0, 1'b0});
    foreach (probes[i]) begin
      typed_val.temp = probes[i].temp;
      typed_val.flag = probes[i].flag;
      // First rows go back to back, then with gaps
      send_code(probes[i].code, (i < 4) ? 0 : $urandom_range(0, GAP_MAX),
                probes[i].typed, typed_val);
    end

    // Per phase: reset values, both extremes, zero beta, a fixed pair, then random
    beta_set = '{16'd3950, 16'd1, 16'd65535, 16'd0, 16'd3435, 16'd0, 16'd0, 16'd0};
    ref_set  = '{16'd2500, 16'h4000, 16'h3FFF, 16'(-4000), 16'd15000, 16'd0, 16'd0,
                 16'd0};
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      if (p >= 5) begin
        beta_set[p] = 16'($urandom_range(1000, 6000));
        ref_set[p] = 16'($urandom_range(0, 19000) - 4000);
      end
      write_reg(tbc_pkg::REG_BETA, beta_set[p]);
      write_reg(tbc_pkg::REG_REF, ref_set[p]);
      // Indexes past the register list must leave the settings alone
      write_reg(2'd2, 16'($urandom));
      write_reg(2'd3, 16'($urandom));
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Alternate bursts with no gaps and stretches of random gaps
        ngap = ((n / 25) % 2 == 0) ? 0 : $urandom_range(0, GAP_MAX);
        send_code(pick_code(), ngap, 0, typed_val);
      end
    end

    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d codes over 8 register settings, %0d results checked, %0d bad",
             words_sent, readings_seen, mismatches);
    if (mismatches == 0 && pending_readings.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tbc_pkg.sv
rtl/tbc_log2.sv
rtl/tbc_div.sv
rtl/tbc_front.sv
rtl/tbc_back.sv
rtl/thermistor_beta_to_celsius.sv
tb/tb_thermistor_beta_to_celsius.sv
